### hw/rtl/srle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SGI RLE scanline decoder package
// Shared types, widths and codes for the 8-bit run-length scanline decoder.
// ----------------------------------------------------------------------------
package srle_pkg;

  // Field widths.
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned WIDTH_W  = 16;
  localparam int unsigned COL_W    = 17;

  localparam logic [COL_W-1:0]   COL_MAX  = 17'h1FFFF;
  localparam logic [WIDTH_W-1:0] COL_OUT_MAX = 16'hFFFF;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 16'd1;
  localparam logic [DATA_W-1:0]  STOP_CODE = 8'h00;

  typedef logic [DATA_W-1:0]  byte_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [WIDTH_W-1:0] width_t;
  typedef logic [COL_W-1:0]   col_t;

  // Line status codes reported on the closing beat.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_SHORT     = 2'd1,
    STAT_OVERFLOW  = 2'd2,
    STAT_TRUNCATED = 2'd3
  } line_status_t;

  // Decoder mode, one-hot.
  typedef enum logic [2:0] {
    MODE_CTRL = 3'b001,
    MODE_RUN  = 3'b010,
    MODE_LIT  = 3'b100
  } mode_t;

endpackage : srle_pkg
`default_nettype wire

### hw/rtl/srle_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SGI RLE channel interfaces
// Valid/ready channels for compressed input, decoded results and config.
// ----------------------------------------------------------------------------

// Compressed byte channel.
interface srle_in_if;
  logic                  valid;
  logic                  ready;
  srle_pkg::byte_t       data_byte;
  logic                  line_end;

  modport source (output valid, output data_byte, output line_end, input ready);
  modport sink   (input valid, input data_byte, input line_end, output ready);
endinterface : srle_in_if

// Decoded result channel.
interface srle_out_if;
  logic                  valid;
  logic                  ready;
  srle_pkg::byte_t       pixel_value;
  srle_pkg::width_t      start_column;
  srle_pkg::count_t      run_length;
  logic                  line_done;
  srle_pkg::line_status_t line_status;

  modport source (output valid, output pixel_value, output start_column,
                  output run_length, output line_done, output line_status,
                  input ready);
  modport sink   (input valid, input pixel_value, input start_column,
                  input run_length, input line_done, input line_status,
                  output ready);
endinterface : srle_out_if

// Configuration write channel for the line width register.
interface srle_cfg_if;
  logic                  valid;
  logic                  ready;
  srle_pkg::width_t      data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : srle_cfg_if
`default_nettype wire

### hw/rtl/sgi_rle_scanline_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Output: a result beat is registered, appearing in the cycle after the input
// beat that causes it. Throughput: one input beat per cycle unless the result
// register is stalled; decode state and column add/clip logic are combinational,
// and the result register refills in the same cycle that its beat is taken.
// Reset: synchronous active-low rst_n clears the decode state and the result
// valid flag and sets the line width to 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
// SGI RLE scanline decoder top level
// Decodes 8-bit SGI run-length bytes into run-form results with line status.
// ----------------------------------------------------------------------------
module sgi_rle_scanline_decoder_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  srle_in_if.sink     in_bus,
  srle_out_if.source  out_bus,
  srle_cfg_if.sink    cfg_bus
);
  import srle_pkg::*;

  // Decode state.
  mode_t  mode_r, mode_nxt, mode_u;
  count_t remain_r, remain_nxt, remain_u;
  col_t   col_r, col_nxt, col_u;
  logic   ovf_r, ovf_nxt, ovf_u;
  logic   stop_r, stop_nxt, stop_u;
  width_t width_r;

  // Result register.
  logic         out_valid_r;
  byte_t        out_val_r;
  width_t       out_col_r;
  count_t       out_len_r;
  logic         out_done_r;
  line_status_t out_stat_r;

  // Datapath signals.
  logic         in_fire;
  logic         in_ready;
  count_t       cov_n;
  col_t         width_ext;
  col_t         room;
  logic         room_gt;
  count_t       vis;
  logic [COL_W:0] col_sum;
  col_t         col_adv;
  width_t       col_out;
  logic         emit_px;
  logic         stop_hit;
  logic         res_valid;
  logic         res_done;
  line_status_t status_u;

  assign in_ready     = !out_valid_r || out_bus.ready;
  assign in_bus.ready = in_ready;
  assign in_fire      = in_bus.valid && in_ready;
  assign cfg_bus.ready = 1'b1;

  // Coverage of the pending pixels: visible span and advanced column.
  assign cov_n     = (mode_r == MODE_RUN) ? remain_r : count_t'(1);
  assign width_ext = {1'b0, width_r};
  assign room_gt   = width_ext > col_r;
  assign room      = width_ext - col_r;
  assign vis       = !room_gt ? '0 :
                     ((col_t'(cov_n) < room) ? cov_n : room[COUNT_W-1:0]);
  assign col_sum   = {1'b0, col_r} + (COL_W+1)'(cov_n);
  assign col_adv   = col_sum[COL_W] ? COL_MAX : col_sum[COL_W-1:0];
  assign col_out   = col_r[COL_W-1] ? COL_OUT_MAX : col_r[WIDTH_W-1:0];

  // Decode one byte and update the line state.
  always_comb begin
    mode_u   = mode_r;
    remain_u = remain_r;
    col_u    = col_r;
    ovf_u    = ovf_r;
    stop_u   = stop_r;
    emit_px  = 1'b0;
    stop_hit = 1'b0;
    if (!stop_r) begin
      case (mode_r)
        MODE_CTRL: begin
          if (in_bus.data_byte == STOP_CODE) begin
            stop_hit = 1'b1;
            stop_u   = 1'b1;
          end else if (in_bus.data_byte[COUNT_W-1:0] != '0) begin
            remain_u = in_bus.data_byte[COUNT_W-1:0];
            mode_u   = in_bus.data_byte[DATA_W-1] ? MODE_LIT : MODE_RUN;
          end
        end
        MODE_RUN: begin
          emit_px  = 1'b1;
          ovf_u    = ovf_r || (vis < cov_n);
          col_u    = col_adv;
          remain_u = '0;
          mode_u   = MODE_CTRL;
        end
        default: begin
          emit_px  = 1'b1;
          ovf_u    = ovf_r || (vis < cov_n);
          col_u    = col_adv;
          remain_u = remain_r - count_t'(1);
          mode_u   = (remain_r == count_t'(1)) ? MODE_CTRL : MODE_LIT;
        end
      endcase
    end
  end

  // Line status from the updated state, truncated first.
  always_comb begin
    if (mode_u != MODE_CTRL) begin
      status_u = STAT_TRUNCATED;
    end else if (ovf_u) begin
      status_u = STAT_OVERFLOW;
    end else if (col_u < width_ext) begin
      status_u = STAT_SHORT;
    end else begin
      status_u = STAT_OK;
    end
  end

  assign res_done  = stop_hit || in_bus.line_end;
  assign res_valid = !stop_r && (emit_px || res_done);

  // A flagged last byte starts a fresh line.
  always_comb begin
    if (in_bus.line_end) begin
      mode_nxt   = MODE_CTRL;
      remain_nxt = '0;
      col_nxt    = '0;
      ovf_nxt    = 1'b0;
      stop_nxt   = 1'b0;
    end else begin
      mode_nxt   = mode_u;
      remain_nxt = remain_u;
      col_nxt    = col_u;
      ovf_nxt    = ovf_u;
      stop_nxt   = stop_u;
    end
  end

  // State and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_CTRL;
      remain_r <= '0;
      col_r    <= '0;
      ovf_r    <= 1'b0;
      stop_r   <= 1'b0;
      width_r  <= WIDTH_RESET;
    end else begin
      if (in_fire) begin
        mode_r   <= mode_nxt;
        remain_r <= remain_nxt;
        col_r    <= col_nxt;
        ovf_r    <= ovf_nxt;
        stop_r   <= stop_nxt;
      end
      if (cfg_bus.valid) begin
        width_r <= cfg_bus.data;
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_fire && res_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_val_r  <= emit_px ? in_bus.data_byte : '0;
      out_col_r  <= col_out;
      out_len_r  <= emit_px ? vis : '0;
      out_done_r <= res_done;
      out_stat_r <= res_done ? status_u : STAT_OK;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.pixel_value  = out_val_r;
  assign out_bus.start_column = out_col_r;
  assign out_bus.run_length   = out_len_r;
  assign out_bus.line_done    = out_done_r;
  assign out_bus.line_status  = out_stat_r;

endmodule : sgi_rle_scanline_decoder_top
`default_nettype wire

### hw/rtl/srle_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SGI RLE scanline decoder checker
// Port-level assertions for the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module srle_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire srle_pkg::byte_t      pixel_value,
  input wire srle_pkg::width_t     start_column,
  input wire srle_pkg::count_t     run_length,
  input wire logic                 line_done,
  input wire logic [1:0]           line_status,
  input wire logic                 cfg_ready
);
  import srle_pkg::*;

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_value) &&
      $stable(start_column) && $stable(run_length) && $stable(line_done) &&
      $stable(line_status))
    else $error("result beat changed while stalled");

  // Only a closing beat carries a status other than ok.
  a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !line_done |-> line_status == STAT_OK)
    else $error("status on a non-closing beat");

  // The input side is open whenever the result register is free or drains.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free result register");

  // A full, stalled result register blocks the input side.
  a_ready_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted over a stalled result");

  // The width register takes every write.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

endmodule : srle_checker

bind sgi_rle_scanline_decoder_top srle_checker u_srle_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_bus.ready),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .pixel_value  (out_bus.pixel_value),
  .start_column (out_bus.start_column),
  .run_length   (out_bus.run_length),
  .line_done    (out_bus.line_done),
  .line_status  (out_bus.line_status),
  .cfg_ready    (cfg_bus.ready)
);
`default_nettype wire

### sim/sgi_rle_scanline_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SGI RLE scanline decoder testbench
// Feeds compressed scanline bytes, line width writes and random back-pressure
// into the decoder. Every result beat is checked field by field against a
// behavioral scanline decoder that runs on the accepted input beats.
// ----------------------------------------------------------------------------
module sgi_rle_scanline_decoder_top_tb;
  import srle_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASE_ITEMS    = 20;
  localparam int unsigned NUM_PHASES     = 9;
  localparam int unsigned LONG_LINE_COLS = 65700;
  localparam byte_t       EMPTY_LITERAL  = 8'h80;

  // One decoded result as it appears on the output channel.
  typedef struct {
    byte_t        pixel_value;
    width_t       start_column;
    count_t       run_length;
    logic         line_done;
    line_status_t line_status;
  } pixel_run_t;

  // One row of the directed table: a width write or a data byte.
  typedef struct {
    bit         is_cfg;
    width_t     cfg_val;
    byte_t      data;
    logic       last;
    bit         typed;
    pixel_run_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  srle_in_if  in_ch ();
  srle_out_if out_ch ();
  srle_cfg_if cfg_ch ();

  sgi_rle_scanline_decoder_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch),
    .cfg_bus (cfg_ch)
  );

  // Decoder state mirrored by the scanline predictor.
  width_t dec_width;
  mode_t  dec_mode;
  count_t dec_remaining;
  col_t   dec_col;
  bit     dec_overflow;
  bit     dec_stopped;

  pixel_run_t  expected_runs[$];
  stim_row_t   dir_rows[$];
  int unsigned dir_ptr;
  int unsigned errors;
  int unsigned stall_cycles;
  int unsigned line_items;
  int unsigned tx_idle;
  int unsigned rx_idle;
  bit          hold_req;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Scanline predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_line();
    dec_mode      = MODE_CTRL;
    dec_remaining = '0;
    dec_col       = '0;
    dec_overflow  = 1'b0;
    dec_stopped   = 1'b0;
  endfunction

  function automatic line_status_t line_state();
    if (dec_mode != MODE_CTRL) return STAT_TRUNCATED;
    if (dec_overflow) return STAT_OVERFLOW;
    if (dec_col < {1'b0, dec_width}) return STAT_SHORT;
    return STAT_OK;
  endfunction

  // Places n pixels at the current column and returns how many fall inside
  // the line; the column advances by the full count, saturating at COL_MAX.
  function automatic count_t cover_columns(input count_t n);
    int unsigned w_cols;
    int unsigned c_cols;
    int unsigned vis;
    int unsigned sum;
    w_cols = dec_width;
    c_cols = dec_col;
    vis = 0;
    if (w_cols > c_cols) begin
      vis = (n < w_cols - c_cols) ? n : w_cols - c_cols;
    end
    if (vis < n) dec_overflow = 1'b1;
    sum = c_cols + n;
    dec_col = (sum > COL_MAX) ? COL_MAX : col_t'(sum);
    return count_t'(vis);
  endfunction

  // Decodes one accepted byte; returns 1 when it yields a result beat.
  function automatic bit decode_byte(input byte_t b, input logic last,
                                     output pixel_run_t r);
    bit pix;
    pix = 1'b0;
    r.pixel_value  = '0;
    r.start_column = (dec_col > {1'b0, COL_OUT_MAX}) ? COL_OUT_MAX
                                                      : dec_col[WIDTH_W-1:0];
    r.run_length   = '0;
    r.line_done    = 1'b0;
    r.line_status  = STAT_OK;

    // After a stop code only the flagged last byte matters.
    if (dec_stopped) begin
      if (last) clear_line();
      return 1'b0;
    end

    case (dec_mode)
      MODE_CTRL: begin
        if (b == STOP_CODE) begin
          r.line_done   = 1'b1;
          r.line_status = line_state();
          if (last) clear_line();
          else dec_stopped = 1'b1;
          return 1'b1;
        end
        // An empty literal leaves the mode untouched.
        if (b[COUNT_W-1:0] != '0) begin
          dec_remaining = b[COUNT_W-1:0];
          dec_mode = b[DATA_W-1] ? MODE_LIT : MODE_RUN;
        end
      end
      MODE_RUN: begin
        r.pixel_value = b;
        r.run_length  = cover_columns(dec_remaining);
        dec_remaining = '0;
        dec_mode      = MODE_CTRL;
        pix           = 1'b1;
      end
      default: begin
        r.pixel_value = b;
        r.run_length  = cover_columns(count_t'(1));
        dec_remaining = dec_remaining - count_t'(1);
        if (dec_remaining == '0) dec_mode = MODE_CTRL;
        pix = 1'b1;
      end
    endcase

    if (last) begin
      r.line_done   = 1'b1;
      r.line_status = line_state();
      clear_line();
      return 1'b1;
    end
    return pix;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------

  function automatic stim_row_t row_width(input width_t w);
    stim_row_t row;
    row.is_cfg  = 1'b1;
    row.cfg_val = w;
    row.data    = '0;
    row.last    = 1'b0;
    row.typed   = 1'b0;
    row.want.pixel_value  = '0;
    row.want.start_column = '0;
    row.want.run_length   = '0;
    row.want.line_done    = 1'b0;
    row.want.line_status  = STAT_OK;
    return row;
  endfunction

  function automatic stim_row_t row_byte(input byte_t b, input logic last);
    stim_row_t row;
    row = row_width('0);
    row.is_cfg = 1'b0;
    row.data   = b;
    row.last   = last;
    return row;
  endfunction

  function automatic stim_row_t row_typed(input byte_t b, input logic last,
                                          input byte_t val, input width_t col,
                                          input count_t len, input logic done,
                                          input line_status_t stat);
    stim_row_t row;
    row = row_byte(b, last);
    row.typed = 1'b1;
    row.want.pixel_value  = val;
    row.want.start_column = col;
    row.want.run_length   = len;
    row.want.line_done    = done;
    row.want.line_status  = stat;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking and bookkeeping
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    errors++;
    if (errors <= 40) begin
      $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    pixel_run_t got;
    pixel_run_t want;
    stim_row_t  row;
    bit         hit;
    bit         pinned;
    bit         any_beat;
    if (rst_n) begin
      any_beat = 1'b0;
      pinned   = 1'b0;

      // Result beat: compare against the oldest expectation.
      if (out_ch.valid && out_ch.ready) begin
        any_beat = 1'b1;
        got.pixel_value  = out_ch.pixel_value;
        got.start_column = out_ch.start_column;
        got.run_length   = out_ch.run_length;
        got.line_done    = out_ch.line_done;
        got.line_status  = out_ch.line_status;
        if (expected_runs.size() == 0) begin
          report_mismatch("unexpected result beat", got.start_column, 0);
        end else begin
          want = expected_runs.pop_front();
          if (got.pixel_value !== want.pixel_value)
            report_mismatch("pixel_value", got.pixel_value, want.pixel_value);
          if (got.start_column !== want.start_column)
            report_mismatch("start_column", got.start_column, want.start_column);
          if (got.run_length !== want.run_length)
            report_mismatch("run_length", got.run_length, want.run_length);
          if (got.line_done !== want.line_done)
            report_mismatch("line_done", got.line_done, want.line_done);
          if (got.line_status !== want.line_status)
            report_mismatch("line_status", got.line_status, want.line_status);
        end
      end

      // Input beat: run the predictor; typed table rows override it.
      if (in_ch.valid && in_ch.ready) begin
        any_beat = 1'b1;
        if (dir_ptr < dir_rows.size()) begin
          row    = dir_rows[dir_ptr];
          pinned = row.typed;
          dir_ptr++;
        end
        hit = decode_byte(in_ch.data_byte, in_ch.line_end, want);
        if (pinned) expected_runs.push_back(row.want);
        else if (hit) expected_runs.push_back(want);
      end

      // Width register write.
      if (cfg_ch.valid && cfg_ch.ready) begin
        any_beat  = 1'b1;
        dec_width = cfg_ch.data;
        if (dir_ptr < dir_rows.size()) dir_ptr++;
      end

      // Watchdog on cycles without any accepted beat.
      if (any_beat) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("sgi_rle_scanline_decoder_top_tb: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls and one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : rx_side
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------

  // Offers one byte, with random idle cycles ahead of it, until accepted.
  task automatic send_beat(input byte_t b, input logic last);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.line_end  <= last;
    do @(posedge clk); while (!in_ch.ready);
    line_items++;
  endtask

  // Stops offering and waits for every expected beat, plus the pipeline.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_runs.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_width(input width_t w);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly short counts, with the odd long one.
  function automatic count_t pick_count();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return count_t'($urandom_range(1, 8));
    if (sel < 90) return count_t'($urandom_range(1, 40));
    return count_t'($urandom_range(100, 127));
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned ph;
    int unsigned base;
    int unsigned pkts;
    int unsigned kind;
    int unsigned ending;
    int unsigned total;
    count_t      n;
    width_t      w;

    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.line_end  = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    rst_n           = 1'b0;
    hold_req        = 1'b0;
    tx_idle         = 22;
    rx_idle         = 22;
    errors          = 0;
    stall_cycles    = 0;
    line_items      = 0;
    dir_ptr         = 0;
    dec_width       = WIDTH_RESET;
    clear_line();

    // Directed table. Width is 1 out of reset.
    dir_rows.push_back(row_typed(STOP_CODE, 1'b0, 8'h00, 16'd0, 7'd0, 1'b1, STAT_SHORT));
    dir_rows.push_back(row_byte(8'h55, 1'b0));          // ignored after stop
    dir_rows.push_back(row_byte(8'hFF, 1'b1));          // silent restart
    dir_rows.push_back(row_width(16'hFFFF));
    dir_rows.push_back(row_byte(8'h7F, 1'b0));          // longest run
    dir_rows.push_back(row_typed(8'hAB, 1'b0, 8'hAB, 16'd0, 7'd127, 1'b0, STAT_OK));
    dir_rows.push_back(row_byte(8'h83, 1'b0));          // three literals
    dir_rows.push_back(row_typed(8'h01, 1'b0, 8'h01, 16'd127, 7'd1, 1'b0, STAT_OK));
    dir_rows.push_back(row_typed(8'hFE, 1'b0, 8'hFE, 16'd128, 7'd1, 1'b0, STAT_OK));
    dir_rows.push_back(row_typed(8'h80, 1'b0, 8'h80, 16'd129, 7'd1, 1'b0, STAT_OK));
    dir_rows.push_back(row_byte(EMPTY_LITERAL, 1'b0));  // empty literal
    dir_rows.push_back(row_typed(STOP_CODE, 1'b1, 8'h00, 16'd130, 7'd0, 1'b1, STAT_SHORT));
    dir_rows.push_back(row_width(16'd0));               // zero width clips all
    dir_rows.push_back(row_byte(8'h05, 1'b0));
    dir_rows.push_back(row_typed(8'h33, 1'b1, 8'h33, 16'd0, 7'd0, 1'b1, STAT_OVERFLOW));
    dir_rows.push_back(row_width(16'd1));
    dir_rows.push_back(row_byte(8'h84, 1'b0));
    dir_rows.push_back(row_typed(8'h10, 1'b0, 8'h10, 16'd0, 7'd1, 1'b0, STAT_OK));
    // Open literal with clipping: truncated wins over overflow.
    dir_rows.push_back(row_typed(8'h11, 1'b1, 8'h11, 16'd1, 7'd0, 1'b1, STAT_TRUNCATED));
    dir_rows.push_back(row_byte(8'h02, 1'b0));
    dir_rows.push_back(row_typed(8'h44, 1'b0, 8'h44, 16'd0, 7'd1, 1'b0, STAT_OK));
    dir_rows.push_back(row_typed(STOP_CODE, 1'b0, 8'h00, 16'd2, 7'd0, 1'b1, STAT_OVERFLOW));
    dir_rows.push_back(row_byte(STOP_CODE, 1'b1));      // silent restart
    // Control byte flagged last: run left open.
    dir_rows.push_back(row_typed(8'h03, 1'b1, 8'h00, 16'd0, 7'd0, 1'b1, STAT_TRUNCATED));
    dir_rows.push_back(row_width(16'd2));
    dir_rows.push_back(row_byte(8'h02, 1'b0));
    dir_rows.push_back(row_typed(8'hC3, 1'b1, 8'hC3, 16'd0, 7'd2, 1'b1, STAT_OK));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_drained();
        write_width(dir_rows[i].cfg_val);
      end else begin
        send_beat(dir_rows[i].data, dir_rows[i].last);
      end
    end

    // Random phases, one line width each.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       w = WIDTH_RESET;
        1:       w = 16'hFFFF;
        6:       w = 16'd128;
        8:       w = width_t'($urandom_range(1, 16'hFFFF));
        default: w = width_t'($urandom_range(1, 200));
      endcase
      // Phases three and four run without any idling on either side.
      tx_idle = (ph == 3 || ph == 4) ? 0 : 22;
      rx_idle = tx_idle;
      wait_drained();
      write_width(w);
      // The receiver holds off while the sender keeps offering bytes.
      if (ph == 2) hold_req = 1'b1;
      base = line_items;
      while (line_items - base < PHASE_ITEMS) begin
        if ($urandom_range(19) == 0) wait_drained();
        pkts = $urandom_range(1, 4);
        for (int k = 0; k < pkts; k++) begin
          kind = $urandom_range(99);
          if (kind < 8) begin
            // Noise byte, now and then flagged last.
            send_beat(byte_t'($urandom), $urandom_range(15) == 0);
          end else if (kind < 12) begin
            send_beat(EMPTY_LITERAL, 1'b0);
          end else if (kind < 55) begin
            n = pick_count();
            send_beat(byte_t'(n), 1'b0);
            send_beat(byte_t'($urandom), 1'b0);
          end else begin
            n = pick_count();
            send_beat(EMPTY_LITERAL | byte_t'(n), 1'b0);
            repeat (n) send_beat(byte_t'($urandom), 1'b0);
          end
        end
        // Close the line in one of several ways.
        ending = $urandom_range(99);
        if (ending < 35) begin
          send_beat(STOP_CODE, 1'b0);
          repeat ($urandom_range(0, 3)) send_beat(byte_t'($urandom), 1'b0);
          send_beat(byte_t'($urandom), 1'b1);
        end else if (ending < 60) begin
          send_beat(STOP_CODE, 1'b1);
        end else if (ending < 85) begin
          n = pick_count();
          send_beat(byte_t'(n), 1'b0);
          send_beat(byte_t'($urandom), 1'b1);
        end else if (ending < 93) begin
          n = count_t'($urandom_range(2, 127));
          send_beat(EMPTY_LITERAL | byte_t'(n), 1'b0);
          send_beat(byte_t'($urandom), 1'b1);
        end else begin
          n = pick_count();
          send_beat(($urandom_range(1) ? EMPTY_LITERAL : 8'h00) | byte_t'(n), 1'b1);
        end
      end
    end

    // One line long enough to saturate the reported start column.
    tx_idle = 22;
    rx_idle = 22;
    wait_drained();
    write_width(16'hFFFF);
    total = 0;
    while (total < LONG_LINE_COLS) begin
      n = count_t'($urandom_range(120, 127));
      send_beat(byte_t'(n), 1'b0);
      send_beat(byte_t'($urandom), 1'b0);
      total += n;
    end
    send_beat(STOP_CODE, 1'b1);

    wait_drained();
    repeat (4) @(posedge clk);
    if (expected_runs.size() != 0)
      report_mismatch("results missing at end", 0, expected_runs.size());
    if (errors == 0) begin
      $display("sgi_rle_scanline_decoder_top_tb: PASS");
    end else begin
      $display("sgi_rle_scanline_decoder_top_tb: FAIL");
    end
    $finish;
  end

endmodule : sgi_rle_scanline_decoder_top_tb
